/* src/sbp_pkg.sv */
// shared types, constants and helpers for the stepper bin positioner
// no dependencies; imported by every module of the block
`default_nettype none

package sbp_pkg;

  // command codes carried on the input channel
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_MOVE = 2'd1;
  localparam logic [1:0] CMD_HOME = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_MAX_DELAY     = 3'd0;
  localparam logic [2:0] CFG_MIN_DELAY     = 3'd1;
  localparam logic [2:0] CFG_HOME_DELAY    = 3'd2;
  localparam logic [2:0] CFG_QUARTER_STEPS = 3'd3;
  localparam logic [2:0] CFG_RAMP_STEPS    = 3'd4;

  // register reset values
  localparam logic [4:0] RST_MAX_DELAY     = 5'd16;
  localparam logic [4:0] RST_MIN_DELAY     = 5'd6;
  localparam logic [7:0] RST_HOME_DELAY    = 8'd20;
  localparam logic [7:0] RST_QUARTER_STEPS = 8'd50;
  localparam logic [7:0] RST_RAMP_STEPS    = 8'd10;

  localparam logic [1:0] HOME_BIN = 2'd1;

  typedef struct packed {
    logic       accepted;
    logic [1:0] bin_position;
    logic       busy_res;
    logic [5:0] coil_pattern;
  } sbp_res_t;

  // full-step coil patterns, phase 1..4 (phase 0 maps like phase 4)
  function automatic logic [5:0] coil_of(input logic [2:0] phase);
    logic [1:0] idx;
    logic [5:0] pat;
    idx = phase[1:0] - 2'd1;
    unique case (idx)
      2'd0: pat = 6'b110000;
      2'd1: pat = 6'b000110;
      2'd2: pat = 6'b101000;
      2'd3: pat = 6'b000101;
      default: pat = 6'b000000;
    endcase
    return pat;
  endfunction

  // next phase in the given direction; ccw from unstepped wraps to 4
  function automatic logic [2:0] phase_step(input logic [2:0] phase, input logic cw);
    logic [2:0] nxt;
    if (cw) begin
      nxt = {1'b0, phase[1:0]} + 3'd1;
    end else if (phase <= 3'd1) begin
      nxt = 3'd4;
    end else begin
      nxt = phase - 3'd1;
    end
    return nxt;
  endfunction

  // a zero hold still lasts one tick
  function automatic logic [7:0] hold_of(input logic [7:0] d);
    return (d == 8'd0) ? 8'd1 : d;
  endfunction

endpackage

`default_nettype wire

/* src/sbp_seq.sv */
// step sequencer: configuration registers, motion state and next-state logic
// depends on sbp_pkg; produces one result per item taken in, whether or not it is accepted
`default_nettype none

module sbp_seq
  import sbp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_addr,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       fire,
  input  wire logic [1:0] command,
  input  wire logic [1:0] target_bin,
  input  wire logic       hall_pulse,
  output sbp_res_t        res
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_HOME = 2'd2
  } mode_t;

  logic [4:0] max_delay_r, min_delay_r;
  logic [7:0] home_delay_r, quarter_steps_r, ramp_steps_r;

  mode_t      mode_r, mode_nxt;
  logic [1:0] position_r, position_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [8:0] steps_left_r, steps_left_nxt;
  logic [8:0] step_count_r, step_count_nxt;
  logic [5:0] step_delay_r, step_delay_nxt;
  logic [7:0] countdown_r, countdown_nxt;
  logic       clockwise_r, clockwise_nxt;
  logic       hall_latch_r, hall_latch_nxt;
  logic [5:0] coils_r, coils_nxt;
  logic [1:0] target_r, target_nxt;
  logic       acc;

  logic [1:0] diff;
  logic [8:0] n_steps;
  logic [7:0] cd_dec;
  logic [5:0] sd_a, sd_b;
  logic [8:0] sl_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_delay_r     <= RST_MAX_DELAY;
      min_delay_r     <= RST_MIN_DELAY;
      home_delay_r    <= RST_HOME_DELAY;
      quarter_steps_r <= RST_QUARTER_STEPS;
      ramp_steps_r    <= RST_RAMP_STEPS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_DELAY:     max_delay_r     <= cfg_wdata[4:0];
        CFG_MIN_DELAY:     min_delay_r     <= cfg_wdata[4:0];
        CFG_HOME_DELAY:    home_delay_r    <= cfg_wdata;
        CFG_QUARTER_STEPS: quarter_steps_r <= cfg_wdata;
        CFG_RAMP_STEPS:    ramp_steps_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_nxt       = mode_r;
    position_nxt   = position_r;
    phase_nxt      = phase_r;
    steps_left_nxt = steps_left_r;
    step_count_nxt = step_count_r;
    step_delay_nxt = step_delay_r;
    countdown_nxt  = countdown_r;
    clockwise_nxt  = clockwise_r;
    hall_latch_nxt = hall_latch_r;
    coils_nxt      = coils_r;
    target_nxt     = target_r;
    acc            = 1'b0;

    diff    = target_bin - position_r;
    n_steps = (diff == 2'd2) ? {quarter_steps_r, 1'b0} : {1'b0, quarter_steps_r};
    cd_dec  = countdown_r - {7'd0, (countdown_r != 8'd0)};
    sl_dec  = steps_left_r - {8'd0, (steps_left_r != 9'd0)};

    // end-of-hold ramp: speed up early, slow down near the end
    if ((step_count_r < {1'b0, ramp_steps_r}) && (step_delay_r >= {1'b0, min_delay_r})
        && (step_delay_r != 6'd0)) begin
      sd_a = step_delay_r - 6'd1;
    end else begin
      sd_a = step_delay_r;
    end
    if ((steps_left_r < {1'b0, ramp_steps_r}) && (sd_a <= {1'b0, max_delay_r})) begin
      sd_b = sd_a + 6'd1;
    end else begin
      sd_b = sd_a;
    end

    if (mode_r == MODE_IDLE && command == CMD_MOVE) begin
      acc = 1'b1;
      if (hall_pulse) begin
        hall_latch_nxt = 1'b1;
      end
      if (diff == 2'd0 || n_steps == 9'd0) begin
        position_nxt = target_bin;
      end else begin
        clockwise_nxt  = (diff != 2'd3);
        steps_left_nxt = n_steps;
        step_count_nxt = 9'd0;
        step_delay_nxt = {1'b0, max_delay_r};
        target_nxt     = target_bin;
        mode_nxt       = MODE_MOVE;
        phase_nxt      = phase_step(phase_r, diff != 2'd3);
        coils_nxt      = coil_of(phase_step(phase_r, diff != 2'd3));
        countdown_nxt  = hold_of({3'd0, max_delay_r});
      end
    end else if (mode_r == MODE_IDLE && command == CMD_HOME) begin
      acc            = 1'b1;
      hall_latch_nxt = hall_pulse;
      if (hall_pulse) begin
        position_nxt = HOME_BIN;
      end else begin
        mode_nxt      = MODE_HOME;
        phase_nxt     = 3'd1;
        coils_nxt     = coil_of(3'd1);
        countdown_nxt = hold_of(home_delay_r);
      end
    end else begin
      if (hall_pulse) begin
        hall_latch_nxt = 1'b1;
      end
      if (mode_r != MODE_IDLE) begin
        countdown_nxt = cd_dec;
        if (cd_dec == 8'd0) begin
          unique case (mode_r)
            MODE_MOVE: begin
              step_delay_nxt = sd_b;
              step_count_nxt = step_count_r + 9'd1;
              steps_left_nxt = sl_dec;
              if (sl_dec == 9'd0) begin
                position_nxt = target_r;
                mode_nxt     = MODE_IDLE;
              end else begin
                phase_nxt     = phase_step(phase_r, clockwise_r);
                coils_nxt     = coil_of(phase_step(phase_r, clockwise_r));
                countdown_nxt = hold_of({2'd0, sd_b});
              end
            end
            MODE_HOME: begin
              if (hall_latch_nxt) begin
                position_nxt = HOME_BIN;
                mode_nxt     = MODE_IDLE;
              end else begin
                phase_nxt     = phase_step(phase_r, 1'b1);
                coils_nxt     = coil_of(phase_step(phase_r, 1'b1));
                countdown_nxt = hold_of(home_delay_r);
              end
            end
            default: ;
          endcase
        end
      end
    end

    res.coil_pattern = coils_nxt;
    res.busy_res     = (mode_nxt != MODE_IDLE);
    res.bin_position = position_nxt;
    res.accepted     = acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      position_r   <= 2'd0;
      phase_r      <= 3'd0;
      steps_left_r <= 9'd0;
      step_count_r <= 9'd0;
      step_delay_r <= 6'd0;
      countdown_r  <= 8'd0;
      clockwise_r  <= 1'b0;
      hall_latch_r <= 1'b0;
      coils_r      <= 6'd0;
      target_r     <= 2'd0;
    end else if (fire) begin
      mode_r       <= mode_nxt;
      position_r   <= position_nxt;
      phase_r      <= phase_nxt;
      steps_left_r <= steps_left_nxt;
      step_count_r <= step_count_nxt;
      step_delay_r <= step_delay_nxt;
      countdown_r  <= countdown_nxt;
      clockwise_r  <= clockwise_nxt;
      hall_latch_r <= hall_latch_nxt;
      coils_r      <= coils_nxt;
      target_r     <= target_nxt;
    end
  end

  // a running move always has steps to go and a live hold
  a_move_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_MOVE) |-> (steps_left_r != 9'd0))
    else $error("move running with no steps left");

  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_IDLE) |-> (countdown_r != 8'd0))
    else $error("busy with an expired hold");

  a_busy_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_IDLE) |-> !res.accepted)
    else $error("command taken while busy");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_IDLE) |-> (phase_r != 3'd0 && phase_r <= 3'd4))
    else $error("phase out of range while stepping");

endmodule

`default_nettype wire

/* src/sbp_out.sv */
// result register between the sequencer and the output channel
// depends on sbp_pkg; frees the input side while the result drains
`default_nettype none

module sbp_out
  import sbp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  sbp_res_t  res,
  input  wire logic out_tready,
  output logic      out_tvalid,
  output sbp_res_t  out_res,
  output logic      can_load
);

  logic     valid_r;
  sbp_res_t data_r;

  // a new item may enter when the slot is empty or drains this cycle
  assign can_load   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

endmodule

`default_nettype wire

/* src/stepper_bin_positioner.sv */
// Four-bin rotary tray positioner: full-step sequencer with delay ramp and homing.
// One item (tick, move or home) is taken per clock and yields one result item,
// registered, in the next cycle; the state update is a single pass through the
// sequencer's next-state logic, and a held result does not stop the next item
// while the consumer takes it in the same cycle. Depends on sbp_pkg, sbp_seq, sbp_out.
`default_nettype none

module stepper_bin_positioner
  import sbp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_addr,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // target_bin[1:0], hall_pulse[2], zero fill
  input  wire logic [1:0] in_tuser,   // command[1:0]
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [15:0]     out_tdata   // coil_pattern[5:0], busy_res[6],
                                      // bin_position[8:7], accepted[9], zero fill
);

  logic     fire;
  logic     can_load;
  sbp_res_t res;
  sbp_res_t out_res;

  assign in_tready = can_load;
  assign fire      = in_tvalid && can_load;

  sbp_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fire       (fire),
    .command    (in_tuser),
    .target_bin (in_tdata[1:0]),
    .hall_pulse (in_tdata[2]),
    .res        (res)
  );

  sbp_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (out_res),
    .can_load   (can_load)
  );

  assign out_tdata = {6'd0, out_res.accepted, out_res.bin_position,
                      out_res.busy_res, out_res.coil_pattern};

endmodule

`default_nettype wire
